FILE: hw/rtl/bta_pkg.sv
// Shared types, constants and search functions for the bitmap tag allocator.
// Used by bta_ctrl, bta_datapath and bitmap_tag_allocator_core; no dependencies.
`default_nettype none
package bta_pkg;

  localparam int WORDS     = 64;
  localparam int WORD_BITS = 32;

  localparam int TAG_IN_W  = 11;
  localparam int TAG_OUT_W = 12;
  localparam int WIDX_W    = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int OFS_W     = (WORD_BITS > 1) ? $clog2(WORD_BITS) : 1;

  localparam logic [TAG_IN_W-1:0] WB_TAG    = TAG_IN_W'(WORD_BITS);
  localparam logic [TAG_IN_W:0]   WORDS_TAG = (TAG_IN_W + 1)'(WORDS);

  localparam logic KIND_ALLOC = 1'b0;
  localparam logic KIND_FREE  = 1'b1;

  localparam logic STATUS_OK        = 1'b0;
  localparam logic STATUS_EXHAUSTED = 1'b1;

  typedef enum logic {
    ST_IDLE,
    ST_MODIFY
  } state_t;

  typedef struct packed {
    logic capture;
    logic commit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic out_stall;
  } dp_stat_t;

  function automatic logic [WIDX_W-1:0] first_open_word(input logic [WORDS-1:0] full);
    logic [WIDX_W-1:0] idx;
    idx = '0;
    for (int i = WORDS - 1; i >= 0; i--) begin
      if (!full[i]) begin
        idx = WIDX_W'(i);
      end
    end
    return idx;
  endfunction

  function automatic logic [OFS_W-1:0] ms_zero_offset(input logic [WORD_BITS-1:0] w);
    logic [OFS_W-1:0] ofs;
    ofs = '0;
    for (int r = WORD_BITS - 1; r >= 0; r--) begin
      if (!w[WORD_BITS-1-r]) begin
        ofs = OFS_W'(r);
      end
    end
    return ofs;
  endfunction

endpackage
`default_nettype wire

FILE: hw/rtl/bta_ctrl.sv
// Controller state machine for the bitmap tag allocator.
// Depends on bta_pkg for the state type and command/status structs.
`default_nettype none
module bta_ctrl (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire bta_pkg::dp_stat_t   stat,
  output bta_pkg::ctrl_cmd_t       cmd
);

  bta_pkg::state_t state;
  bta_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= bta_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      bta_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_next = bta_pkg::ST_MODIFY;
        end
      end
      bta_pkg::ST_MODIFY: begin
        if (!stat.out_stall) begin
          state_next = bta_pkg::ST_IDLE;
        end
      end
      default: state_next = bta_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready    = 1'b0;
    cmd.capture = 1'b0;
    cmd.commit  = 1'b0;
    case (state)
      bta_pkg::ST_IDLE: begin
        in_ready    = 1'b1;
        cmd.capture = in_valid;
      end
      bta_pkg::ST_MODIFY: begin
        cmd.commit = !stat.out_stall;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

endmodule
`default_nettype wire

FILE: hw/rtl/bta_datapath.sv
// Datapath: bitmap memory, per-word valid and full vectors, search and output register.
// Depends on bta_pkg; driven by bta_ctrl commands.
`default_nettype none
module bta_datapath (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire bta_pkg::ctrl_cmd_t                  cmd,
  output bta_pkg::dp_stat_t                        stat,
  input  wire logic                                in_kind,
  input  wire logic [bta_pkg::TAG_IN_W-1:0]        in_tag,
  output logic                                     out_valid,
  input  wire logic                                out_ready,
  output logic signed [bta_pkg::TAG_OUT_W-1:0]     out_tag,
  output logic                                     out_status
);

  logic [bta_pkg::WORD_BITS-1:0] mem [bta_pkg::WORDS];
  logic [bta_pkg::WORDS-1:0]     vld;
  logic [bta_pkg::WORDS-1:0]     full;

  logic                          kind_q;
  logic [bta_pkg::WIDX_W-1:0]    word_q;
  logic [bta_pkg::OFS_W-1:0]     ofs_q;
  logic                          exh_q;
  logic                          in_range_q;
  logic                          vld_q;
  logic [bta_pkg::WORD_BITS-1:0] rdata;

  logic [bta_pkg::TAG_IN_W-1:0]  tag_word;
  logic                          tag_in_range;
  logic [bta_pkg::WIDX_W-1:0]    addr;

  logic [bta_pkg::WORD_BITS-1:0] cur_word;
  logic [bta_pkg::OFS_W-1:0]     alloc_ofs;
  logic [bta_pkg::OFS_W-1:0]     sel_ofs;
  logic [bta_pkg::WORD_BITS-1:0] bit_mask;
  logic [bta_pkg::WORD_BITS-1:0] wdata;
  logic                          we;
  logic [31:0]                   tag_sum;

  assign tag_word     = in_tag / bta_pkg::WB_TAG;
  assign tag_in_range = {1'b0, tag_word} < bta_pkg::WORDS_TAG;
  assign addr = (in_kind == bta_pkg::KIND_FREE) ? tag_word[bta_pkg::WIDX_W-1:0]
                                                : bta_pkg::first_open_word(full);

  assign cur_word  = vld_q ? rdata : '0;
  assign alloc_ofs = bta_pkg::ms_zero_offset(cur_word);
  assign sel_ofs   = (kind_q == bta_pkg::KIND_FREE) ? ofs_q : alloc_ofs;
  assign bit_mask  = bta_pkg::WORD_BITS'(1)
                     << (bta_pkg::OFS_W'(bta_pkg::WORD_BITS - 1) - sel_ofs);
  assign wdata     = (kind_q == bta_pkg::KIND_FREE) ? (cur_word & ~bit_mask)
                                                    : (cur_word | bit_mask);
  assign we        = cmd.commit && ((kind_q == bta_pkg::KIND_FREE) ? in_range_q : !exh_q);
  assign tag_sum   = 32'(word_q) * 32'(bta_pkg::WORD_BITS) + 32'(alloc_ofs);

  assign stat.out_stall = out_valid && !out_ready;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      kind_q     <= in_kind;
      word_q     <= addr;
      ofs_q      <= bta_pkg::OFS_W'(in_tag % bta_pkg::WB_TAG);
      exh_q      <= &full;
      in_range_q <= tag_in_range;
      vld_q      <= vld[addr];
      rdata      <= mem[addr];
    end
    if (we) begin
      mem[word_q] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld  <= '0;
      full <= '0;
    end else if (we) begin
      vld[word_q]  <= 1'b1;
      full[word_q] <= &wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.commit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      if (kind_q == bta_pkg::KIND_FREE) begin
        out_tag    <= '1;
        out_status <= bta_pkg::STATUS_OK;
      end else if (exh_q) begin
        out_tag    <= '1;
        out_status <= bta_pkg::STATUS_EXHAUSTED;
      end else begin
        out_tag    <= tag_sum[bta_pkg::TAG_OUT_W-1:0];
        out_status <= bta_pkg::STATUS_OK;
      end
    end
  end

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |-> !(out_valid && !out_ready))
    else $error("result register overwritten while held");

  a_exhausted_flag: assert property (@(posedge clk) disable iff (rst)
    (cmd.capture && in_kind == bta_pkg::KIND_ALLOC && (&full)) |=> exh_q)
    else $error("exhausted flag missed with every word full");

  a_write_marks_valid: assert property (@(posedge clk) disable iff (rst)
    we |=> vld[$past(word_q)])
    else $error("written word not marked valid");

  a_exhausted_tag: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_status == bta_pkg::STATUS_EXHAUSTED) |-> (&out_tag))
    else $error("exhausted result carries a tag");

endmodule
`default_nettype wire

FILE: hw/rtl/bitmap_tag_allocator_core.sv
// Bitmap tag allocator top level: stream ports, controller and datapath.
// Depends on bta_pkg, bta_ctrl and bta_datapath.
// A request beat is captured into the input registers; its result is registered when the write-back commits.
// A new request is taken only in ST_IDLE, once the last one's search and memory read, then write-back, are done.
// A held result stalls the write-back, and with it the input, until it is taken.
// Reset clears the word valid and full flags at once; no clearing pass is run.
`default_nettype none
module bitmap_tag_allocator_core (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [15:0] s_axis_tdata,   // [10:0] freed_tag, [15:11] zero
  input  wire logic        s_axis_tuser,   // [0] kind
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [15:0]      m_axis_tdata,   // [11:0] granted_tag, [15:12] zero
  output logic             m_axis_tuser    // [0] status
);

  bta_pkg::ctrl_cmd_t cmd;
  bta_pkg::dp_stat_t  stat;
  logic signed [bta_pkg::TAG_OUT_W-1:0] granted_tag;

  bta_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  bta_datapath u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .stat       (stat),
    .in_kind    (s_axis_tuser),
    .in_tag     (s_axis_tdata[bta_pkg::TAG_IN_W-1:0]),
    .out_valid  (m_axis_tvalid),
    .out_ready  (m_axis_tready),
    .out_tag    (granted_tag),
    .out_status (m_axis_tuser)
  );

  assign m_axis_tdata = {{(16 - bta_pkg::TAG_OUT_W){1'b0}}, granted_tag};

endmodule
`default_nettype wire
